// ----- rtl/core/table_driven_fsm_engine_top_macros.svh -----
// Assertion macros shared by the table-driven state machine engine.
`ifndef TABLE_DRIVEN_FSM_ENGINE_TOP_MACROS_SVH
`define TABLE_DRIVEN_FSM_ENGINE_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TDFSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define TDFSM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/core/tdfsm_pkg.sv -----
// Types, constants and codes of the table-driven state machine engine.
package tdfsm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLEN_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SCAN_W      = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_SIZE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd2;

  // Request operation codes
  localparam logic [2:0] MODE_POST    = 3'd0;
  localparam logic [2:0] MODE_STEP    = 3'd1;
  localparam logic [2:0] MODE_TIME    = 3'd2;
  localparam logic [2:0] MODE_LOAD    = 3'd3;
  localparam logic [2:0] MODE_RESTART = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  event_code;
    logic [15:0] time_increment;
    logic [15:0] guard_bits;
    logic [15:0] decision_bits;
    logic [3:0]  load_index;
    logic [3:0]  load_from_state;
    logic [3:0]  load_event;
    logic [3:0]  load_next_state;
    logic [3:0]  load_alt_state;
    logic        load_has_alt;
  } req_t;

  typedef struct packed {
    logic [3:0]  state_now;
    logic        state_changed;
    logic        ran_do_action;
    logic        ran_exit_and_transition;
    logic        ran_entry_action;
    logic        entry_matched;
    logic [3:0]  matched_index;
    logic        event_taken;
    logic        event_dropped;
    logic [3:0]  queue_level;
    logic [15:0] time_in_state;
  } rsp_t;

  // One transition table entry
  typedef struct packed {
    logic [3:0] from_state;
    logic [3:0] event_code;
    logic [3:0] next_state;
    logic [3:0] alt_state;
    logic       has_alt;
  } tbl_entry_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] index;
    tbl_entry_t        entry;
  } tbl_wr_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [3:0] data;
  } ring_cmd_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [3:0] level;
    logic [3:0] rdata;
  } ring_stat_t;

  typedef struct packed {
    logic       done;
    logic       hit;
    logic       fire;
    logic [3:0] index;
    logic [3:0] target;
  } scan_res_t;

  // Per-request flags gathered before the response is built
  typedef struct packed {
    logic       changed;
    logic       do_act;
    logic       exit_act;
    logic       entry_act;
    logic       matched;
    logic [3:0] index;
    logic       taken;
    logic       dropped;
  } flags_t;

endpackage

// ----- rtl/core/tdfsm_ring.sv -----
// Event ring queue: storage, head and tail pointers, fill level.
module tdfsm_ring import tdfsm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [QLEN_W-1:0] len,
  input  ring_cmd_t         cmd,
  output ring_stat_t        stat
);

  logic [3:0]        mem [QUEUE_DEPTH];
  logic [3:0]        rdata;
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QPTR_W-1:0] tail_inc;
  logic [QPTR_W-1:0] head_inc;
  logic [QLEN_W-1:0] tail_p1;
  logic [QLEN_W-1:0] head_p1;
  logic [QLEN_W-1:0] level_wide;

  // Advance pointers with wrap at the ring length in use
  always_comb begin
    tail_p1  = QLEN_W'(tail) + QLEN_W'(1);
    head_p1  = QLEN_W'(head) + QLEN_W'(1);
    tail_inc = (tail_p1 >= len) ? '0 : tail_p1[QPTR_W-1:0];
    head_inc = (head_p1 >= len) ? '0 : head_p1[QPTR_W-1:0];
    if (tail >= head) begin
      level_wide = QLEN_W'(tail) - QLEN_W'(head);
    end else begin
      level_wide = QLEN_W'(tail) + len - QLEN_W'(head);
    end
  end

  assign stat.full  = (tail_inc == head);
  assign stat.empty = (tail == head);
  assign stat.level = level_wide[3:0];
  assign stat.rdata = rdata;

  // Update pointers; clear wins over push and pop
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (cmd.push) begin
        tail <= tail_inc;
      end
      if (cmd.pop) begin
        head <= head_inc;
      end
    end
  end

  // Write at tail, read at head into a register
  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      mem[tail] <= cmd.data;
    end
    rdata <= mem[head];
  end

endmodule

// ----- rtl/core/tdfsm_scan.sv -----
// Transition table memory and the entry-by-entry match unit.
module tdfsm_scan import tdfsm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  tbl_wr_t           wr,
  input  logic              start,
  input  logic              run,
  input  logic [3:0]        ev_in,
  input  logic [3:0]        cur_state,
  input  logic [SCAN_W-1:0] limit,
  input  logic [15:0]       guard_bits,
  input  logic [15:0]       decision_bits,
  output scan_res_t         res
);

  tbl_entry_t        mem [TABLE_DEPTH];
  tbl_entry_t        tbl_q;
  logic [SCAN_W-1:0] idx;
  logic [SCAN_W-1:0] idx_p1;
  logic [TBL_AW-1:0] raddr;
  logic [3:0]        ev;
  logic              in_range;
  logic              hit;

  assign idx_p1 = idx + SCAN_W'(1);
  assign raddr  = start ? '0 : idx_p1[TBL_AW-1:0];

  // Compare the entry under the counter with state and event
  assign in_range = (idx < limit);
  assign hit      = in_range && (tbl_q.from_state == cur_state) && (tbl_q.event_code == ev);

  assign res.done   = run && (!in_range || hit);
  assign res.hit    = hit;
  assign res.index  = idx[3:0];
  assign res.fire   = guard_bits[idx[3:0]];
  assign res.target = (tbl_q.has_alt && !decision_bits[idx[3:0]]) ? tbl_q.alt_state
                                                                  : tbl_q.next_state;

  // Write entries and read the next one to compare
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.index] <= wr.entry;
    end
    tbl_q <= mem[raddr];
  end

  // Hold the event and step the entry counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (start) begin
      idx <= '0;
    end else if (run && !res.done) begin
      idx <= idx_p1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ev <= ev_in;
    end
  end

endmodule

// ----- rtl/core/table_driven_fsm_engine_top.sv -----
// Table-driven state machine engine: request sequencer, state, time and response register.
// Post, add time, load, restart and unused modes go via execute and finish to the result.
// A step on an empty queue does the same; else it pops an event, fetches the first entry and
// compares table entries in the single compare unit until one matches or the entries run out.
// One request in work at a time; a new one is taken while a result waits.
// Synchronous reset: state 0, time 0, queue empty, queue_size 16, no entries in use.
`include "table_driven_fsm_engine_top_macros.svh"

module table_driven_fsm_engine_top import tdfsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req_data,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_FETCH  = 5'b00100,
    S_SCAN   = 5'b01000,
    S_FINISH = 5'b10000
  } fsm_t;

  fsm_t              state;
  fsm_t              state_next;
  req_t              item;
  flags_t            flags;
  flags_t            flags_next;
  logic [3:0]        cur_state;
  logic [3:0]        cur_state_next;
  logic [15:0]       ticks;
  logic [15:0]       ticks_next;
  logic [3:0]        initial_state;
  logic [4:0]        queue_size;
  logic [4:0]        entries_in_use;
  logic [QLEN_W-1:0] len;
  logic [SCAN_W-1:0] limit;
  logic              out_free;
  ring_cmd_t         ring_cmd;
  ring_stat_t        ring_stat;
  tbl_wr_t           tbl_wr;
  scan_res_t         scan_res;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // Clamp ring length and search count to the storage present
  always_comb begin
    if (queue_size < 5'd2) begin
      len = QLEN_W'(2);
    end else if (32'(queue_size) > QUEUE_DEPTH) begin
      len = QLEN_W'(QUEUE_DEPTH);
    end else begin
      len = QLEN_W'(queue_size);
    end
    if (32'(entries_in_use) > TABLE_DEPTH) begin
      limit = SCAN_W'(TABLE_DEPTH);
    end else begin
      limit = SCAN_W'(entries_in_use);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_state  <= '0;
      queue_size     <= 5'd16;
      entries_in_use <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INITIAL_STATE:  initial_state  <= cfg_data[3:0];
        CFG_QUEUE_SIZE:     queue_size     <= cfg_data;
        CFG_ENTRIES_IN_USE: entries_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: decode the request, drive queue, table and compare unit
  always_comb begin
    state_next     = state;
    flags_next     = flags;
    cur_state_next = cur_state;
    ticks_next     = ticks;
    ring_cmd       = '0;
    ring_cmd.data  = item.event_code;
    ring_cmd.clear = cfg_we && (cfg_index == CFG_QUEUE_SIZE);
    tbl_wr         = '0;
    tbl_wr.index   = item.load_index[TBL_AW-1:0];
    tbl_wr.entry   = '{from_state: item.load_from_state, event_code: item.load_event,
                       next_state: item.load_next_state, alt_state: item.load_alt_state,
                       has_alt: item.load_has_alt};
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        flags_next = '0;
        state_next = S_FINISH;
        case (item.mode)
          MODE_POST: begin
            if (ring_stat.full) begin
              flags_next.dropped = 1'b1;
            end else begin
              ring_cmd.push = 1'b1;
            end
          end
          MODE_STEP: begin
            if (ring_stat.empty) begin
              flags_next.do_act = 1'b1;
            end else begin
              ring_cmd.pop     = 1'b1;
              flags_next.taken = 1'b1;
              state_next       = S_FETCH;
            end
          end
          MODE_TIME: begin
            ticks_next = ticks + item.time_increment;
          end
          MODE_LOAD: begin
            tbl_wr.we = (32'(item.load_index) < TABLE_DEPTH);
          end
          MODE_RESTART: begin
            ring_cmd.clear       = 1'b1;
            cur_state_next       = initial_state;
            ticks_next           = '0;
            flags_next.entry_act = 1'b1;
          end
          default: ;
        endcase
      end
      S_FETCH: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_res.done) begin
          state_next = S_FINISH;
          if (scan_res.hit) begin
            flags_next.matched = 1'b1;
            flags_next.index   = scan_res.index;
            if (scan_res.fire) begin
              flags_next.exit_act  = 1'b1;
              flags_next.changed   = 1'b1;
              flags_next.entry_act = 1'b1;
              cur_state_next       = scan_res.target;
              ticks_next           = '0;
            end else begin
              flags_next.do_act = 1'b1;
            end
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state and machine state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_state <= '0;
      ticks     <= '0;
    end else begin
      state     <= state_next;
      cur_state <= cur_state_next;
      ticks     <= ticks_next;
    end
  end

  // Hold the accepted request and the gathered flags
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      item <= req_data;
    end
    flags <= flags_next;
  end

  // Response register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      rsp_data <= '{state_now: cur_state, state_changed: flags.changed,
                    ran_do_action: flags.do_act, ran_exit_and_transition: flags.exit_act,
                    ran_entry_action: flags.entry_act, entry_matched: flags.matched,
                    matched_index: flags.index, event_taken: flags.taken,
                    event_dropped: flags.dropped, queue_level: ring_stat.level,
                    time_in_state: ticks};
    end
  end

  tdfsm_ring u_ring (
    .clk  (clk),
    .rst  (rst),
    .len  (len),
    .cmd  (ring_cmd),
    .stat (ring_stat)
  );

  tdfsm_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .wr            (tbl_wr),
    .start         (state == S_FETCH),
    .run           (state == S_SCAN),
    .ev_in         (ring_stat.rdata),
    .cur_state     (cur_state),
    .limit         (limit),
    .guard_bits    (item.guard_bits),
    .decision_bits (item.decision_bits),
    .res           (scan_res)
  );

  `TDFSM_ASSERT(a_rsp_after_finish, $rose(rsp_valid) |-> $past(state == S_FINISH), "response without finish")
  `TDFSM_ASSERT(a_scan_done_finish, (state == S_SCAN && scan_res.done) |=> (state == S_FINISH), "scan did not finish")
  `TDFSM_NEVER(a_push_full, ring_cmd.push && ring_stat.full, "push into full queue")
  `TDFSM_ASSERT(a_level_bound, {1'b0, ring_stat.level} < len, "queue level beyond ring length")

endmodule
